[rtl/rpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the RMS power accumulator
// Field widths, register codes, reset values and the job record passed
// from the sample front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package rpa_pkg;

	// field and datapath widths
	localparam int SampleW = 16;
	localparam int SqW     = 31;                  // square of a 16-bit sample
	localparam int SumW    = 41;                  // sum of up to 2047 squares
	localparam int CntW    = 11;
	localparam int ScaleW  = 24;
	localparam int PowerW  = 31;
	localparam int FracW   = 16;                  // mean-square fraction bits
	localparam int QuotW   = SumW + FracW;        // 57-bit mean square
	localparam int RootW   = (QuotW + 1) / 2;     // 29-bit root
	localparam int ProdW   = RootW + ScaleW;      // 53-bit scaled root
	localparam int CfgIdxW = 2;

	// clamp of the samples-per-result register
	localparam logic [CntW-1:0] MaxSamples = CntW'(1024);

	// reset values of the configuration registers
	localparam logic [CntW-1:0]   SampleCountRst = CntW'(10);
	localparam logic [ScaleW-1:0] PowerScaleRst  = ScaleW'(13112);

	// default depth of the job queue
	localparam int JobDepth = 2;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SAMPLE_COUNT = 2'd0,
		CFG_POWER_SCALE  = 2'd1
	} cfg_idx_t;

	// one finished run, handed to the back end
	typedef struct packed {
		logic            fault;
		logic [SumW-1:0] sum;
		logic [CntW-1:0] n;
	} job_t;

	// fill status of the job queue, seen by the front end
	typedef struct packed {
		logic no_room;
		logic one_room;
	} q_stat_t;

endpackage

[rtl/rpa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_front: sample intake and accumulation
// Squares each accepted sample, adds it to the running sum and emits a job
// when a run completes or a converter fault aborts it.
// ----------------------------------------------------------------------------
module rpa_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [rpa_pkg::SampleW-1:0]  sample,
	input  logic                                fault,
	input  logic        [rpa_pkg::CntW-1:0]     sample_count,
	input  rpa_pkg::q_stat_t                    q_stat,
	output logic                                job_push,
	output rpa_pkg::job_t                       job
);

	logic                         vld_s1;
	logic                         fault_s1;
	logic [rpa_pkg::SqW-1:0]      sq_s1;
	logic [rpa_pkg::SumW-1:0]     sum_q;
	logic [rpa_pkg::CntW-1:0]     taken_q;

	logic signed [2*rpa_pkg::SampleW-1:0] sq_full;
	logic [rpa_pkg::SumW-1:0]     acc_sum;
	logic [rpa_pkg::CntW-1:0]     acc_taken;
	logic [rpa_pkg::CntW-1:0]     eff_n;
	logic                         run_done;

	// hold off while the queue could overflow with the item in flight
	assign full = q_stat.no_room || (q_stat.one_room && vld_s1);

	// square is never negative and at most 2^30
	assign sq_full = sample * sample;

	// effective run length
	always_comb begin
		if (sample_count == '0) begin
			eff_n = rpa_pkg::CntW'(1);
		end else if (sample_count > rpa_pkg::MaxSamples) begin
			eff_n = rpa_pkg::MaxSamples;
		end else begin
			eff_n = sample_count;
		end
	end

	// accumulate and detect end of run
	assign acc_sum   = sum_q + rpa_pkg::SumW'(sq_s1);
	assign acc_taken = taken_q + rpa_pkg::CntW'(1);
	assign run_done  = fault_s1 || (acc_taken >= eff_n);
	assign job_push  = vld_s1 && run_done;

	always_comb begin
		job.fault = fault_s1;
		job.sum   = acc_sum;
		job.n     = eff_n;
	end

	// square stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= push && !full;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1    <= sq_full[rpa_pkg::SqW-1:0];
		fault_s1 <= fault;
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (vld_s1) begin
			if (run_done) begin
				sum_q   <= '0;
				taken_q <= '0;
			end else begin
				sum_q   <= acc_sum;
				taken_q <= acc_taken;
			end
		end
	end

endmodule

[rtl/rpa_job_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_job_fifo: job queue between front end and back end
// Small register queue of finished runs; reports how much room is left.
// ----------------------------------------------------------------------------
module rpa_job_fifo #(
	parameter int DEPTH = rpa_pkg::JobDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rpa_pkg::job_t    wr_data,
	input  logic             rd,
	output logic             rd_valid,
	output rpa_pkg::job_t    rd_data,
	output rpa_pkg::q_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [LW-1:0] Full    = LW'(DEPTH);
	localparam logic [LW-1:0] OneLeft = LW'(DEPTH - 1);

	rpa_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [LW-1:0]   level_q;
	logic            do_rd;

	assign do_rd         = rd && rd_valid;
	assign rd_valid      = (level_q != '0);
	assign rd_data       = mem_q[rp_q];
	assign stat.no_room  = (level_q == Full);
	assign stat.one_room = (level_q == OneLeft);

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == LastPtr) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LastPtr) ? '0 : rp_q + AW'(1);
			end
			if (wr && !do_rd) begin
				level_q <= level_q + LW'(1);
			end else if (!wr && do_rd) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	// the front end must never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (level_q != Full || do_rd))
		else $error("job queue written while full");

endmodule

[rtl/rpa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_back: mean, root and scaling of one run
// Restoring divide of the shifted sum by the run length, digit-by-digit
// square root, one scale multiply and saturation into a result register.
// ----------------------------------------------------------------------------
module rpa_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	input  rpa_pkg::job_t                  job,
	output logic                           job_pop,
	input  logic [rpa_pkg::ScaleW-1:0]     power_scale,
	output logic                           empty,
	input  logic                           pop,
	output logic [rpa_pkg::PowerW-1:0]     power_watts,
	output logic                           fault_seen
);

	localparam int QuotW = rpa_pkg::QuotW;
	localparam int RootW = rpa_pkg::RootW;
	localparam int CntW  = rpa_pkg::CntW;
	localparam int ProdW = rpa_pkg::ProdW;
	localparam int ItW   = $clog2(QuotW);
	localparam int RemW  = 2 * RootW + 2 - RootW + 1;   // root + 3 bits
	localparam int HiW   = ProdW - rpa_pkg::FracW;      // 37 bits after shift

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [ItW-1:0]            it_q;
	logic [CntW-1:0]           n_q;
	logic [CntW-1:0]           drem_q;
	logic [QuotW-1:0]          w_q;
	logic [2*RootW-1:0]        sv_q;
	logic [RootW-1:0]          root_q;
	logic [RemW-1:0]           srem_q;
	logic [ProdW-1:0]          prod_q;
	logic                      fault_q;
	logic                      res_vld_q;
	logic [rpa_pkg::PowerW-1:0] power_q;
	logic                      fault_seen_q;

	logic [CntW:0]             div_sh;
	logic                      div_ge;
	logic [CntW-1:0]           drem_nx;
	logic [QuotW-1:0]          w_nx;
	logic [RemW-1:0]           sqrt_sh;
	logic [RemW-1:0]           trial;
	logic                      sqrt_ge;
	logic [HiW-1:0]            prod_hi;
	logic [rpa_pkg::PowerW-1:0] power_sat;

	assign job_pop     = (state_q == ST_IDLE) && job_valid;
	assign empty       = !res_vld_q;
	assign power_watts = power_q;
	assign fault_seen  = fault_seen_q;

	// one restoring divide step
	always_comb begin
		div_sh  = {drem_q, w_q[QuotW-1]};
		div_ge  = (div_sh >= {1'b0, n_q});
		drem_nx = div_ge ? CntW'(div_sh - {1'b0, n_q}) : div_sh[CntW-1:0];
		w_nx    = {w_q[QuotW-2:0], div_ge};
	end

	// one square-root digit (two radicand bits)
	always_comb begin
		sqrt_sh = {srem_q[RemW-3:0], sv_q[2*RootW-1 -: 2]};
		trial   = RemW'({root_q, 2'b01});
		sqrt_ge = (sqrt_sh >= trial);
	end

	// drop fraction bits and saturate
	always_comb begin
		prod_hi = prod_q[ProdW-1:rpa_pkg::FracW];
		if (prod_hi[HiW-1:rpa_pkg::PowerW] != '0) begin
			power_sat = '1;
		end else begin
			power_sat = prod_hi[rpa_pkg::PowerW-1:0];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_vld_q    <= 1'b0;
			it_q         <= '0;
			n_q          <= '0;
			drem_q       <= '0;
			w_q          <= '0;
			sv_q         <= '0;
			root_q       <= '0;
			srem_q       <= '0;
			prod_q       <= '0;
			fault_q      <= 1'b0;
			power_q      <= '0;
			fault_seen_q <= 1'b0;
		end else begin
			if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						fault_q <= job.fault;
						n_q     <= job.n;
						drem_q  <= '0;
						w_q     <= {job.sum, {rpa_pkg::FracW{1'b0}}};
						it_q    <= ItW'(QuotW - 1);
						if (job.fault) begin
							prod_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					drem_q <= drem_nx;
					w_q    <= w_nx;
					it_q   <= it_q - ItW'(1);
					if (it_q == '0) begin
						sv_q    <= (2*RootW)'(w_nx);
						root_q  <= '0;
						srem_q  <= '0;
						it_q    <= ItW'(RootW - 1);
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sv_q   <= {sv_q[2*RootW-3:0], 2'b00};
					root_q <= {root_q[RootW-2:0], sqrt_ge};
					srem_q <= sqrt_ge ? (sqrt_sh - trial) : sqrt_sh;
					it_q   <= it_q - ItW'(1);
					if (it_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= root_q * power_scale;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_vld_q) begin
						power_q      <= power_sat;
						fault_seen_q <= fault_q;
						res_vld_q    <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divide remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (drem_q < n_q))
		else $error("divide remainder out of range");

	// a fault job goes straight to the result with zero power
	a_fault_path: assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && job.fault) |=> (state_q == ST_OUT && prod_q == '0 && fault_q))
		else $error("fault job did not bypass the arithmetic");

	// a new result only comes out of the output state
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> ($past(state_q) == ST_OUT))
		else $error("result register loaded outside output state");

endmodule

[rtl/rms_power_accumulator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_power_accumulator_unit: RMS power meter over converter samples
// Sums squared samples over a programmable run, then emits the scaled
// square root of the mean square in watts (8 fraction bits).
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------
//  input     push / full          sample[15:0] signed, fault
//  result    pop / empty          power_watts[30:0], fault_seen
//  config    cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[23:0]
//
//  Front end: one sample per cycle while full is low, summed after a square stage.
//  Back end: idle, a 57-step divide, a 29-digit root, the scale multiply and the
//  output state per run; a fault transaction skips the arithmetic states.
//  full rises when the job queue has no room for the sample in flight; the
//  back end holds in its output state until the earlier result is popped.
//  Reset clears the run sum, the queue and the result register at once.
//
module rms_power_accumulator_unit #(
	parameter int JOB_DEPTH = rpa_pkg::JobDepth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [rpa_pkg::SampleW-1:0]   sample,
	input  logic                                 fault,
	output logic                                 empty,
	input  logic                                 pop,
	output logic        [rpa_pkg::PowerW-1:0]    power_watts,
	output logic                                 fault_seen,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [rpa_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic        [rpa_pkg::ScaleW-1:0]    cfg_data
);

	logic [rpa_pkg::CntW-1:0]   sample_count_q;
	logic [rpa_pkg::ScaleW-1:0] power_scale_q;

	logic             job_push;
	rpa_pkg::job_t    job_in;
	rpa_pkg::job_t    job_out;
	logic             job_valid;
	logic             job_pop;
	rpa_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= rpa_pkg::SampleCountRst;
			power_scale_q  <= rpa_pkg::PowerScaleRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rpa_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[rpa_pkg::CntW-1:0];
				rpa_pkg::CFG_POWER_SCALE:  power_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample intake
	rpa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.fault        (fault),
		.sample_count (sample_count_q),
		.q_stat       (q_stat),
		.job_push     (job_push),
		.job          (job_in)
	);

	// queue of finished runs
	rpa_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (job_push),
		.wr_data  (job_in),
		.rd       (job_pop),
		.rd_valid (job_valid),
		.rd_data  (job_out),
		.stat     (q_stat)
	);

	// arithmetic and result
	rpa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job_out),
		.job_pop     (job_pop),
		.power_scale (power_scale_q),
		.empty       (empty),
		.pop         (pop),
		.power_watts (power_watts),
		.fault_seen  (fault_seen)
	);

endmodule
